// ----- design/lpft_pkg.sv -----
// ----------------------------------------------------------------------------
// lpft_pkg: shared types and constants of the LRU page-frame tracker
// Payload structs, cell control, controller states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lpft_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_W     = 20;
   localparam int CNT_W      = 32;
   localparam int CFG_W      = 7;
   localparam int PAGE_SHIFT = 12;
   localparam int MAX_FRAMES = 64;

   localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(64);

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic              is_write;
   } req_payload_type;

   typedef struct packed {
      logic              hit;
      logic              disk_read;
      logic              disk_write;
      logic [PAGE_W-1:0] evicted_page;
      logic [CNT_W-1:0]  reads_total;
      logic [CNT_W-1:0]  writes_total;
      logic [CNT_W-1:0]  accesses_total;
   } rsp_payload_type;

   // Control broadcast from the controller to every cell.
   typedef struct packed {
      logic upd;  // commit the stack update this cycle
      logic hit;  // key found in the stack
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

endpackage

`default_nettype wire

// ----- design/lpft_channels.sv -----
// ----------------------------------------------------------------------------
// lpft channels: valid/ready handshake interfaces for requests and responses
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpft_req_if;
   logic                     valid;
   logic                     ready;
   lpft_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lpft_rsp_if;
   logic                     valid;
   logic                     ready;
   lpft_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lpft_cell.sv -----
// ----------------------------------------------------------------------------
// lpft_cell: one entry of the LRU stack
// Holds a page and its dirty bit, compares against the key, takes the entry
// above it when the stack shifts down.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_cell #(
   parameter int MAX_FRAMES = lpft_pkg::MAX_FRAMES,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                        clock,
   input  wire lpft_pkg::cell_ctl_type      ctl,
   input  wire logic [lpft_pkg::PAGE_W-1:0] key,
   input  wire logic [$clog2(MAX_FRAMES+1)-1:0] occ,
   input  wire logic [$clog2(MAX_FRAMES+1)-1:0] last_idx,
   input  wire logic [$clog2(MAX_FRAMES+1)-1:0] evict_idx,
   input  wire logic [lpft_pkg::PAGE_W-1:0] prev_page,
   input  wire logic                        prev_dirty,
   input  wire logic                        suffix_in,
   output logic                             suffix_out,
   output logic                             match,
   output logic [lpft_pkg::PAGE_W-1:0]      page_out,
   output logic                             dirty_out,
   output logic [lpft_pkg::PAGE_W-1:0]      evict_page,
   output logic                             evict_dirty,
   output logic                             hit_dirty
);

   localparam int OCC_W = $clog2(MAX_FRAMES+1);
   localparam logic [OCC_W-1:0] IDX = OCC_W'(CELL_INDEX);

   logic [lpft_pkg::PAGE_W-1:0] page_ff, page_in;
   logic                        dirty_ff, dirty_in;
   logic                        shift;
   logic                        bottom;

   assign match      = (IDX < occ) && (page_ff == key);
   assign suffix_out = suffix_in | match;
   // on a hit every entry at or above the hit moves; on a miss down to last_idx
   assign shift      = ctl.hit ? suffix_out : (IDX <= last_idx);
   assign bottom     = (IDX == evict_idx);

   always_comb begin
      page_in  = page_ff;
      dirty_in = dirty_ff;
      if (ctl.upd && shift) begin
         page_in  = prev_page;
         dirty_in = prev_dirty;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      dirty_ff <= dirty_in;
   end

   assign page_out    = page_ff;
   assign dirty_out   = dirty_ff;
   assign evict_page  = bottom ? page_ff : '0;
   assign evict_dirty = bottom & dirty_ff;
   assign hit_dirty   = match & dirty_ff;

endmodule

`default_nettype wire

// ----- design/lru_page_frame_tracker_top.sv -----
// ----------------------------------------------------------------------------
// lru_page_frame_tracker_top: fully associative LRU page-frame tracker
// Flow: an accepted request is registered and moves the controller to busy;
//    the update commits, and the response loads once its register is free.
// Accesses do not overlap: each makes the single compare-and-shift pass
//    over the cell chain; a stalled response holds the next access.
// Reset: synchronous; occupancy and counters clear, limit returns to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_tracker_top #(
   parameter int MAX_FRAMES = lpft_pkg::MAX_FRAMES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lpft_req_if.sink                        req_chan,
   lpft_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_write_enable,
   input  wire logic [lpft_pkg::CFG_W-1:0] csr_write_data
);

   localparam int OCC_W = $clog2(MAX_FRAMES+1);
   localparam int LIM_W = (OCC_W > lpft_pkg::CFG_W) ? OCC_W : lpft_pkg::CFG_W;
   localparam int PW    = lpft_pkg::PAGE_W;
   localparam int CW    = lpft_pkg::CNT_W;

   // ---- controller state -------------------------------------------------
   lpft_pkg::state_type state_ff, state_in;
   logic [lpft_pkg::CFG_W-1:0] frames_ff;
   logic [OCC_W-1:0]           occ_ff, occ_in;
   logic [CW-1:0]              reads_ff, reads_in;
   logic [CW-1:0]              writes_ff, writes_in;
   logic [CW-1:0]              access_ff, access_in;
   logic [PW-1:0]              key_ff, key_in;
   logic                       wr_ff, wr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lpft_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   // ---- cell chain wiring -----------------------------------------------
   lpft_pkg::cell_ctl_type ctl;
   logic [PW-1:0] cell_page  [MAX_FRAMES];
   logic          cell_dirty [MAX_FRAMES];
   logic [PW-1:0] cell_evict [MAX_FRAMES];
   logic          cell_edirty[MAX_FRAMES];
   logic          cell_hdirty[MAX_FRAMES];
   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES:0]   suffix;

   logic              req_xfer;
   logic              hit;
   logic              full;
   logic              top_dirty;
   logic              hit_dirty;
   logic [PW-1:0]     evict_page;
   logic              evict_dirty;
   logic [LIM_W-1:0]  limit;
   logic [OCC_W-1:0]  last_idx;
   logic [OCC_W-1:0]  evict_idx;

   // ---- handshake --------------------------------------------------------
   // Take a new access only while idle; the update commits once the output
   // register is free or being drained this cycle.
   assign req_chan.ready = (state_ff == lpft_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign ctl.upd        = (state_ff == lpft_pkg::ST_BUSY) &&
                           (!rsp_valid_ff || rsp_chan.ready);

   // ---- frame limit: zero acts as one, saturate at the stack depth --------
   always_comb begin
      limit = LIM_W'(frames_ff);
      if (frames_ff == '0)
         limit = LIM_W'(1);
      else if (LIM_W'(frames_ff) > LIM_W'(MAX_FRAMES))
         limit = LIM_W'(MAX_FRAMES);
   end

   assign full      = (LIM_W'(occ_ff) >= limit);
   assign hit       = |match;
   assign ctl.hit   = hit;
   // on a full miss the bottom entry is overwritten; otherwise the stack grows
   assign last_idx  = full ? occ_ff - OCC_W'(1) : occ_ff;
   assign evict_idx = occ_ff - OCC_W'(1);
   assign top_dirty = wr_ff | (hit & hit_dirty);

   // ---- cell chain: entry 0 is most recent --------------------------------
   assign suffix[MAX_FRAMES] = 1'b0;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic [PW-1:0] prev_page;
      logic          prev_dirty;

      if (i == 0) begin : g_top
         assign prev_page  = key_ff;
         assign prev_dirty = top_dirty;
      end else begin : g_mid
         assign prev_page  = cell_page[i-1];
         assign prev_dirty = cell_dirty[i-1];
      end

      lpft_cell #(
         .MAX_FRAMES (MAX_FRAMES),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (key_ff),
         .occ         (occ_ff),
         .last_idx    (last_idx),
         .evict_idx   (evict_idx),
         .prev_page   (prev_page),
         .prev_dirty  (prev_dirty),
         .suffix_in   (suffix[i+1]),
         .suffix_out  (suffix[i]),
         .match       (match[i]),
         .page_out    (cell_page[i]),
         .dirty_out   (cell_dirty[i]),
         .evict_page  (cell_evict[i]),
         .evict_dirty (cell_edirty[i]),
         .hit_dirty   (cell_hdirty[i])
      );
   end

   // Collect the per-cell contributions; at most one cell drives each.
   always_comb begin
      evict_page  = '0;
      evict_dirty = 1'b0;
      hit_dirty   = 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         evict_page  = evict_page | cell_evict[i];
         evict_dirty = evict_dirty | cell_edirty[i];
         hit_dirty   = hit_dirty | cell_hdirty[i];
      end
   end

   // ---- next-state logic -------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      reads_in     = reads_ff;
      writes_in    = writes_ff;
      access_in    = access_ff;
      key_in       = key_ff;
      wr_in        = wr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the response once its transfer completes
      if (rsp_valid_ff && rsp_chan.ready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         lpft_pkg::ST_IDLE: begin
            if (req_xfer) begin
               key_in   = PW'(req_chan.data.byte_address >> lpft_pkg::PAGE_SHIFT);
               wr_in    = req_chan.data.is_write;
               state_in = lpft_pkg::ST_BUSY;
            end
         end
         lpft_pkg::ST_BUSY: begin
            if (ctl.upd) begin
               access_in = access_ff + CW'(1);
               rsp_data_in.hit          = hit;
               rsp_data_in.disk_read    = !hit;
               rsp_data_in.disk_write   = 1'b0;
               rsp_data_in.evicted_page = '0;
               if (!hit) begin
                  reads_in = reads_ff + CW'(1);
                  if (full) begin
                     rsp_data_in.evicted_page = evict_page;
                     rsp_data_in.disk_write   = evict_dirty;
                     if (evict_dirty)
                        writes_in = writes_ff + CW'(1);
                  end else begin
                     occ_in = occ_ff + OCC_W'(1);
                  end
               end
               rsp_data_in.reads_total    = reads_in;
               rsp_data_in.writes_total   = writes_in;
               rsp_data_in.accesses_total = access_in;
               rsp_valid_in = 1'b1;
               state_in     = lpft_pkg::ST_IDLE;
            end
         end
         default: state_in = lpft_pkg::ST_IDLE;
      endcase
   end

   // ---- registers --------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpft_pkg::ST_IDLE;
         frames_ff    <= lpft_pkg::FRAMES_RESET;
         occ_ff       <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         access_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         access_ff    <= access_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable)
            frames_ff <= csr_write_data;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      wr_ff       <= wr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // ---- assertions -------------------------------------------------------
   // Resident pages are unique, so a lookup never finds two entries.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpft_pkg::ST_BUSY) |-> $onehot0(match))
      else $error("more than one stack entry matched the key");

   // Occupancy never grows past the stack depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (LIM_W'(occ_ff) <= LIM_W'(MAX_FRAMES)))
      else $error("occupancy exceeds the stack depth");

   // A fresh response follows a committed update.
   a_rsp_after_upd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.upd))
      else $error("response raised without a stack update");

   // Every update produces exactly one of hit or disk read, and a disk write
   // only comes with a disk read.
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      ctl.upd |=> (rsp_data_ff.hit != rsp_data_ff.disk_read) &&
                  (!rsp_data_ff.disk_write || rsp_data_ff.disk_read))
      else $error("inconsistent hit, disk read and disk write flags");

endmodule

`default_nettype wire
